// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the encoder controller.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a caller-supplied message, disabled while in reset.
`define DTROC_ASSERT_MSG(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Clocked assertion with a generic message.
`define DTROC_ASSERT(label, clk, rstn, prop) \
    `DTROC_ASSERT_MSG(label, clk, rstn, prop, "encoder assertion failed")

`endif

// ----- rtl/core/dtroc_pkg.sv -----
// Package for the dense-to-relative-offset CSR encoder: sizes, constants,
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package dtroc_pkg;

    // Sizing of the matrix and the entry counter.
    localparam int MAX_COLS   = 1024;
    localparam int COUNT_BITS = 24;
    localparam int PAD_SPAN   = 16;

    // Field widths of the two channels.
    localparam int VALUE_BITS = 32;
    localparam int OFS_BITS   = $clog2(PAD_SPAN);
    localparam int IDX_WIDTH  = 24;

    // Width of the pending zero run and of the padding entry counter.
    localparam int RUN_BITS = $clog2(MAX_COLS);
    localparam int PAD_BITS = RUN_BITS - OFS_BITS + 1;
    localparam logic [RUN_BITS-1:0] RUN_MAX = RUN_BITS'(MAX_COLS - 1);
    localparam logic [OFS_BITS-1:0] PAD_OFFSET = OFS_BITS'(PAD_SPAN - 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_pad;
        logic load_final;
    } dtroc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_zero;
        logic in_row_last;
        logic in_has_pads;
        logic pad_last;
    } dtroc_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/dtroc_ctrl.sv -----
// Controller of the encoder: sequences acceptance, padding beats and the
// final beat of each item, and owns the result valid flag. Uses dtroc_pkg.
`default_nettype none
`include "assert_macros.svh"

module dtroc_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    input  wire dtroc_pkg::dtroc_status_t st,
    output dtroc_pkg::dtroc_cmd_t         cmd
);
    import dtroc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PAD   = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // The output register can take a new beat when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state and datapath commands.
    always_comb begin
        state_next     = state_reg;
        cmd.accept     = 1'b0;
        cmd.load_pad   = 1'b0;
        cmd.load_final = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (!st.in_zero) begin
                        state_next = st.in_has_pads ? ST_PAD : ST_FINAL;
                    end else if (st.in_row_last) begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_PAD: begin
                if (out_free) begin
                    cmd.load_pad = 1'b1;
                    if (st.pad_last) begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    cmd.load_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on a load, cleared when the beat is taken.
    always_comb begin
        if (cmd.load_pad || cmd.load_final) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A held result beat is never overwritten.
    `DTROC_ASSERT(a_no_overwrite, aclk, aresetn, (m_valid_reg && !m_ready) |-> !(cmd.load_pad || cmd.load_final))
    // The final beat of an item returns the controller to idle.
    `DTROC_ASSERT(a_final_to_idle, aclk, aresetn, cmd.load_final |=> (state_reg == ST_IDLE))
    // A nonzero element always leaves beats to send.
    `DTROC_ASSERT(a_nonzero_busy, aclk, aresetn, (cmd.accept && !st.in_zero) |=> (state_reg != ST_IDLE))
    // The last padding beat is followed by the entry itself.
    `DTROC_ASSERT(a_pad_then_final, aclk, aresetn, (cmd.load_pad && st.pad_last) |=> (state_reg == ST_FINAL))

endmodule

`default_nettype wire

// ----- rtl/core/dtroc_dp.sv -----
// Datapath of the encoder: zero run and entry count state, the held input
// element, the padding counter and the result register. Uses dtroc_pkg.
`default_nettype none

module dtroc_dp (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire dtroc_pkg::dtroc_cmd_t                 cmd,
    output dtroc_pkg::dtroc_status_t                   st,
    input  wire logic [dtroc_pkg::VALUE_BITS-1:0]      s_value_bits,
    input  wire logic                                  s_row_last,
    input  wire logic                                  s_matrix_first,
    output logic                                       m_entry_valid,
    output logic [dtroc_pkg::VALUE_BITS-1:0]           m_entry_value,
    output logic [dtroc_pkg::OFS_BITS-1:0]             m_zero_offset,
    output logic                                       m_row_end,
    output logic [dtroc_pkg::IDX_WIDTH-1:0]            m_row_end_index,
    output logic                                       m_last
);
    import dtroc_pkg::*;

    // State carried between items.
    logic [RUN_BITS-1:0]   zero_run_reg, zero_run_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // Held element and padding counter.
    logic [VALUE_BITS-1:0] held_value_reg, held_value_next;
    logic                  held_row_last_reg, held_row_last_next;
    logic                  held_zero_reg, held_zero_next;
    logic [OFS_BITS-1:0]   held_offset_reg, held_offset_next;
    logic [PAD_BITS-1:0]   pad_left_reg, pad_left_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic [OFS_BITS-1:0]   out_offset_reg, out_offset_next;
    logic                  out_row_end_reg, out_row_end_next;
    logic [IDX_WIDTH-1:0]  out_index_reg, out_index_next;
    logic                  out_last_reg, out_last_next;

    logic                  in_zero;
    logic [RUN_BITS-1:0]   run_eff;
    logic [RUN_BITS-1:0]   run_inc;
    logic [PAD_BITS-1:0]   pads_in;
    logic [COUNT_BITS-1:0] count_inc;

    // Input classification; a new matrix starts from an empty run.
    assign in_zero   = (s_value_bits[VALUE_BITS-2:0] == '0);
    assign run_eff   = s_matrix_first ? '0 : zero_run_reg;
    assign run_inc   = (run_eff < RUN_MAX) ? (run_eff + 1'b1) : run_eff;
    assign pads_in   = PAD_BITS'(run_eff >> OFS_BITS);
    assign count_inc = count_reg + 1'b1;

    assign st.in_zero     = in_zero;
    assign st.in_row_last = s_row_last;
    assign st.in_has_pads = (pads_in != '0);
    assign st.pad_last    = (pad_left_reg == PAD_BITS'(1));

    // Run, count and held element updates.
    always_comb begin
        zero_run_next      = zero_run_reg;
        count_next         = count_reg;
        held_value_next    = held_value_reg;
        held_row_last_next = held_row_last_reg;
        held_zero_next     = held_zero_reg;
        held_offset_next   = held_offset_reg;
        pad_left_next      = pad_left_reg;
        if (cmd.accept) begin
            held_value_next    = s_value_bits;
            held_row_last_next = s_row_last;
            held_zero_next     = in_zero;
            held_offset_next   = run_eff[OFS_BITS-1:0];
            pad_left_next      = pads_in;
            if (s_matrix_first) begin
                count_next = '0;
            end
            if (in_zero && !s_row_last) begin
                zero_run_next = run_inc;
            end else begin
                zero_run_next = '0;
            end
        end else if (cmd.load_pad) begin
            count_next    = count_inc;
            pad_left_next = pad_left_reg - 1'b1;
        end else if (cmd.load_final && !held_zero_reg) begin
            count_next = count_inc;
        end
    end

    // Result beat contents.
    always_comb begin
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_offset_next  = out_offset_reg;
        out_row_end_next = out_row_end_reg;
        out_index_next   = out_index_reg;
        out_last_next    = out_last_reg;
        if (cmd.load_pad) begin
            out_valid_next   = 1'b1;
            out_value_next   = '0;
            out_offset_next  = PAD_OFFSET;
            out_row_end_next = 1'b0;
            out_index_next   = '0;
            out_last_next    = 1'b0;
        end else if (cmd.load_final) begin
            out_valid_next   = !held_zero_reg;
            out_value_next   = held_zero_reg ? '0 : held_value_reg;
            out_offset_next  = held_zero_reg ? '0 : held_offset_reg;
            out_row_end_next = held_row_last_reg;
            out_last_next    = 1'b1;
            if (!held_row_last_reg) begin
                out_index_next = '0;
            end else if (held_zero_reg) begin
                out_index_next = IDX_WIDTH'(count_reg);
            end else begin
                out_index_next = IDX_WIDTH'(count_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg <= '0;
            count_reg    <= '0;
        end else begin
            zero_run_reg <= zero_run_next;
            count_reg    <= count_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        held_value_reg    <= held_value_next;
        held_row_last_reg <= held_row_last_next;
        held_zero_reg     <= held_zero_next;
        held_offset_reg   <= held_offset_next;
        pad_left_reg      <= pad_left_next;
        out_valid_reg     <= out_valid_next;
        out_value_reg     <= out_value_next;
        out_offset_reg    <= out_offset_next;
        out_row_end_reg   <= out_row_end_next;
        out_index_reg     <= out_index_next;
        out_last_reg      <= out_last_next;
    end

    assign m_entry_valid   = out_valid_reg;
    assign m_entry_value   = out_value_reg;
    assign m_zero_offset   = out_offset_reg;
    assign m_row_end       = out_row_end_reg;
    assign m_row_end_index = out_index_reg;
    assign m_last          = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dense_to_relative_offset_csr.sv -----
// Top level of the dense-to-relative-offset CSR encoder.
// Joins dtroc_ctrl and dtroc_dp; uses dtroc_pkg.
//
// Channel   Direction  Handshake          Beat
// s_        in         s_valid/s_ready    one dense element with row and matrix flags
// m_        out        m_valid/m_ready    one entry, padding entry or row-end marker
//
// A zero element that does not end its row makes no beat; a zero that ends it makes a
// row-end marker. A nonzero element makes P padding beats, P = (zeros before it) / 16,
// at most 63, then its entry; one beat per cycle goes out while the output is free.
// Reset clears the zero run, the entry count and the output valid; no clearing pass.
// While m_ready is low the output beat holds; the next element is still taken,
// but any beat it makes waits, and so does every element after it.
`default_nettype none

module dense_to_relative_offset_csr (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [dtroc_pkg::VALUE_BITS-1:0] s_value_bits,
    input  wire logic                             s_row_last,
    input  wire logic                             s_matrix_first,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_entry_valid,
    output logic [dtroc_pkg::VALUE_BITS-1:0]      m_entry_value,
    output logic [dtroc_pkg::OFS_BITS-1:0]        m_zero_offset,
    output logic                                  m_row_end,
    output logic [dtroc_pkg::IDX_WIDTH-1:0]       m_row_end_index,
    output logic                                  m_last
);
    import dtroc_pkg::*;

    dtroc_cmd_t    cmd;
    dtroc_status_t st;

    // Sequencing of beats.
    dtroc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // State, held element and result register.
    dtroc_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .st              (st),
        .s_value_bits    (s_value_bits),
        .s_row_last      (s_row_last),
        .s_matrix_first  (s_matrix_first),
        .m_entry_valid   (m_entry_valid),
        .m_entry_value   (m_entry_value),
        .m_zero_offset   (m_zero_offset),
        .m_row_end       (m_row_end),
        .m_row_end_index (m_row_end_index),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the dense-to-relative-offset CSR encoder.
// Drives dense elements, predicts every entry, padding and row-end beat, and
// compares them in order; depends on dtroc_pkg and dense_to_relative_offset_csr.
`timescale 1ns / 100ps

module tb_top;

    import dtroc_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 80;

    // One dense element as it goes into the encoder.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value_bits;
        logic                  row_last;
        logic                  matrix_first;
    } dense_elem_t;

    // One beat of the compressed stream.
    typedef struct packed {
        logic                  entry_valid;
        logic [VALUE_BITS-1:0] entry_value;
        logic [OFS_BITS-1:0]   zero_offset;
        logic                  row_end;
        logic [IDX_WIDTH-1:0]  row_end_index;
        logic                  last;
    } csr_beat_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [VALUE_BITS-1:0] s_value_bits   = '0;
    logic                  s_row_last     = 1'b0;
    logic                  s_matrix_first = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_entry_valid;
    logic [VALUE_BITS-1:0] m_entry_value;
    logic [OFS_BITS-1:0]   m_zero_offset;
    logic                  m_row_end;
    logic [IDX_WIDTH-1:0]  m_row_end_index;
    logic                  m_last;

    dense_to_relative_offset_csr dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value_bits    (s_value_bits),
        .s_row_last      (s_row_last),
        .s_matrix_first  (s_matrix_first),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_entry_valid   (m_entry_valid),
        .m_entry_value   (m_entry_value),
        .m_zero_offset   (m_zero_offset),
        .m_row_end       (m_row_end),
        .m_row_end_index (m_row_end_index),
        .m_last          (m_last)
    );

    dense_elem_t pending_elems[$];
    csr_beat_t   expected_csr[$];

    // Encoder state as the predictor sees it.
    logic [RUN_BITS-1:0]   pred_zero_run    = '0;
    logic [COUNT_BITS-1:0] pred_entry_count = '0;

    int  error_count   = 0;
    int  elems_sent    = 0;
    int  random_elems  = 0;
    int  pad_beats     = 0;
    int  entry_beats   = 0;
    int  marker_beats  = 0;
    int  idle_cycles   = 0;
    int  send_gap      = 0;
    int  recv_stall    = 0;
    bit  burst_mode    = 1'b0;
    logic in_taken     = 1'b0;

    // Clock generation.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode) begin
            return 0;
        end
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Works out the beats that one accepted element causes and queues them.
    task automatic encode_element(input dense_elem_t elem);
        csr_beat_t           burst[64];
        csr_beat_t           beat;
        int                  n;
        int                  pads;
        logic                is_zero;
        n = 0;
        is_zero = (elem.value_bits[VALUE_BITS-2:0] == '0);
        if (elem.matrix_first) begin
            pred_entry_count = '0;
            pred_zero_run = '0;
        end
        if (is_zero) begin
            if (pred_zero_run < RUN_MAX) begin
                pred_zero_run = pred_zero_run + 1'b1;
            end
        end else begin
            // Every full run of sixteen zeros becomes a padding entry first.
            pads = int'(pred_zero_run) / PAD_SPAN;
            for (int i = 0; i < pads; i++) begin
                beat = '0;
                beat.entry_valid = 1'b1;
                beat.zero_offset = PAD_OFFSET;
                burst[n] = beat;
                n++;
                pred_entry_count = pred_entry_count + 1'b1;
            end
            beat = '0;
            beat.entry_valid = 1'b1;
            beat.entry_value = elem.value_bits;
            beat.zero_offset = pred_zero_run[OFS_BITS-1:0];
            burst[n] = beat;
            n++;
            pred_entry_count = pred_entry_count + 1'b1;
            pred_zero_run = '0;
        end
        // Row end rides on the last beat, or on a bare marker beat.
        if (elem.row_last) begin
            if (n == 0) begin
                burst[0] = '0;
                n = 1;
            end
            burst[n-1].row_end = 1'b1;
            burst[n-1].row_end_index = pred_entry_count[IDX_WIDTH-1:0];
            pred_zero_run = '0;
        end
        if (n > 0) begin
            burst[n-1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_csr.push_back(burst[i]);
        end
    endtask

    task automatic queue_elem(input logic [VALUE_BITS-1:0] v, input logic rl,
                              input logic mf);
        dense_elem_t elem;
        elem.value_bits = v;
        elem.row_last = rl;
        elem.matrix_first = mf;
        pending_elems.push_back(elem);
    endtask

    function automatic logic [VALUE_BITS-1:0] random_zero();
        return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000;
    endfunction

    function automatic logic [VALUE_BITS-1:0] random_nonzero();
        logic [VALUE_BITS-1:0] v;
        v = $urandom;
        if (v[VALUE_BITS-2:0] == '0) begin
            v[$urandom_range(0, VALUE_BITS-2)] = 1'b1;
        end
        return v;
    endfunction

    // One row of random content, sometimes with long zero runs, an early
    // matrix start or a missing row end.
    task automatic queue_random_row();
        int   len;
        int   zero_pct;
        int   run_len;
        logic mf;
        logic rl;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 30);
        case ($urandom_range(0, 4))
            0: zero_pct = 0;
            1: zero_pct = 30;
            2: zero_pct = 60;
            3: zero_pct = 85;
            default: zero_pct = 100;
        endcase
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 24) == 0) begin
                run_len = $urandom_range(16, 70);
                for (int z = 0; z < run_len; z++) begin
                    queue_elem(random_zero(), 1'b0, 1'b0);
                end
                random_elems += run_len;
            end
            mf = (k == 0) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 59) == 0);
            rl = (k == len - 1) && ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 99) < zero_pct) begin
                queue_elem(random_zero(), rl, mf);
            end else begin
                queue_elem(random_nonzero(), rl, mf);
            end
            random_elems++;
        end
    endtask

    // Input side: feeds pending elements with random gaps.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_elems.size() != 0) begin
                    s_value_bits   <= pending_elems[0].value_bits;
                    s_row_last     <= pending_elems[0].row_last;
                    s_matrix_first <= pending_elems[0].matrix_first;
                    pending_elems.pop_front();
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0) begin
                        burst_mode = ~burst_mode;
                    end
                    send_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random back-pressure.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else if (!burst_mode && $urandom_range(0, 7) == 0) begin
                recv_stall = pick_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Checks each output beat against the oldest prediction, then predicts
    // for the element accepted at this edge.
    always @(posedge aclk) begin
        csr_beat_t got;
        csr_beat_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.entry_valid   = m_entry_valid;
                got.entry_value   = m_entry_value;
                got.zero_offset   = m_zero_offset;
                got.row_end       = m_row_end;
                got.row_end_index = m_row_end_index;
                got.last          = m_last;
                if (expected_csr.size() == 0) begin
                    report_mismatch($sformatf("beat with nothing expected: %h", got));
                end else begin
                    want = expected_csr.pop_front();
                    if (got.entry_valid !== want.entry_valid)
                        report_mismatch($sformatf("entry_valid got %b want %b",
                                                  got.entry_valid, want.entry_valid));
                    if (got.entry_value !== want.entry_value)
                        report_mismatch($sformatf("entry_value got %h want %h",
                                                  got.entry_value, want.entry_value));
                    if (got.zero_offset !== want.zero_offset)
                        report_mismatch($sformatf("zero_offset got %0d want %0d",
                                                  got.zero_offset, want.zero_offset));
                    if (got.row_end !== want.row_end)
                        report_mismatch($sformatf("row_end got %b want %b",
                                                  got.row_end, want.row_end));
                    if (got.row_end_index !== want.row_end_index)
                        report_mismatch($sformatf("row_end_index got %0d want %0d",
                                                  got.row_end_index, want.row_end_index));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last got %b want %b",
                                                  got.last, want.last));
                    if (!want.entry_valid) begin
                        marker_beats++;
                    end else if (want.entry_value == '0) begin
                        pad_beats++;
                    end else begin
                        entry_beats++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                encode_element({s_value_bits, s_row_last, s_matrix_first});
                elems_sent++;
            end
            in_taken <= s_valid && s_ready;
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no beat moved in %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        // Opening matrix: zeros of both signs, trailing zeros, odd patterns.
        queue_elem(32'h3F80_0000, 1'b0, 1'b1);
        queue_elem(32'h8000_0000, 1'b0, 1'b0);
        queue_elem(32'h0000_0000, 1'b0, 1'b0);
        queue_elem(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_elem(32'h0000_0000, 1'b1, 1'b0);
        queue_elem(32'h8000_0001, 1'b1, 1'b0);
        // All-zero row.
        queue_elem(32'h8000_0000, 1'b1, 1'b0);
        // New matrix with exactly one padding run before the entry.
        queue_elem(32'h0000_0000, 1'b0, 1'b1);
        for (int z = 0; z < 15; z++) begin
            queue_elem((z % 2) ? 32'h8000_0000 : 32'h0000_0000, 1'b0, 1'b0);
        end
        queue_elem(32'h7FFF_FFFF, 1'b1, 1'b0);
        // Unfinished row cut short by a new matrix.
        queue_elem(32'h4000_0000, 1'b0, 1'b0);
        queue_elem(32'h0080_0000, 1'b1, 1'b1);

        // Random rows, some with zero runs long enough for several pads.
        while (random_elems < 295) begin
            queue_random_row();
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (pending_elems.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_csr.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_csr.size() != 0) begin
            report_mismatch($sformatf("%0d beats never arrived", expected_csr.size()));
        end

        $display("Sent %0d dense elements, with long zero runs and matrix restarts.",
                 elems_sent);
        $display("Checked %0d entries, %0d padding beats and %0d row-end markers.",
                 entry_beats, pad_beats, marker_beats);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
